[src/kdlp_pkg.sv]
`default_nettype none

package kdlp_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned KeyW       = 3;
  localparam int unsigned EventW     = 2;
  localparam int unsigned CfgIdxW    = 1;
  // Key index zero-extended wide enough to compare against the largest key count.
  localparam int unsigned KeyExtW    = 7;
  localparam int unsigned NumKeysDef = 8;

  localparam logic [TimeW-1:0] DebounceRst  = 32'd50;
  localparam logic [TimeW-1:0] LongPressRst = 32'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_UP      = 4'b0001,
    PH_DB_DOWN = 4'b0010,
    PH_DOWN    = 4'b0100,
    PH_DB_UP   = 4'b1000
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_LONG    = 2'd2
  } event_e;

  typedef struct packed {
    phase_e           phase;
    logic [TimeW-1:0] start;
  } entry_t;

  localparam entry_t EntryRst = '{phase: PH_UP, start: '0};

endpackage

`default_nettype wire

[src/kdlp_in_if.sv]
`default_nettype none

interface kdlp_in_if;
  logic                       valid;
  logic                       ready;
  logic [kdlp_pkg::KeyW-1:0]  key_index;
  logic                       level;
  logic [kdlp_pkg::TimeW-1:0] now;

  modport source (output valid, key_index, level, now, input ready);
  modport sink   (input valid, key_index, level, now, output ready);
endinterface

`default_nettype wire

[src/kdlp_out_if.sv]
`default_nettype none

interface kdlp_out_if;
  logic                        valid;
  logic                        ready;
  logic [kdlp_pkg::EventW-1:0] event_res;
  logic [kdlp_pkg::KeyW-1:0]   event_key;

  modport source (output valid, event_res, event_key, input ready);
  modport sink   (input valid, event_res, event_key, output ready);
endinterface

`default_nettype wire

[src/kdlp_ram.sv]
`default_nettype none

module kdlp_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/key_debounce_long_press.sv]
// A sample enters stage 1 as its state RAM entry is read; an event then enters the output
// register. Throughput: one sample per cycle unless an event waits on the output;
// write-back is on leaving stage 1, with a one-entry bypass for back-to-back keys.
// Reset: asynchronous and active low; every key reads as up with start time zero
// through per-key valid flags, and the thresholds return to 50 and 500 ticks.
`default_nettype none

module key_debounce_long_press #(
  parameter int unsigned NumKeys = kdlp_pkg::NumKeysDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  kdlp_in_if.sink                           in_i,
  kdlp_out_if.source                        out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [kdlp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [kdlp_pkg::TimeW-1:0]   cfg_wdata_i
);

  localparam int unsigned AddrW = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam int unsigned EntW  = $bits(kdlp_pkg::entry_t);

  // Configuration registers.
  logic [kdlp_pkg::TimeW-1:0] deb_q, lp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= kdlp_pkg::DebounceRst;
      lp_q  <= kdlp_pkg::LongPressRst;
    end else if (cfg_we_i) begin
      unique case (kdlp_pkg::cfg_idx_e'(cfg_index_i))
        kdlp_pkg::CFG_DEBOUNCE:   deb_q <= cfg_wdata_i;
        kdlp_pkg::CFG_LONG_PRESS: lp_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input side.
  logic [kdlp_pkg::KeyExtW-1:0] key_ext;
  logic                         key_ok;
  logic [AddrW-1:0]             raddr;
  logic                         in_fire;

  assign key_ext = {{(kdlp_pkg::KeyExtW - kdlp_pkg::KeyW){1'b0}}, in_i.key_index};
  assign key_ok  = key_ext < kdlp_pkg::KeyExtW'(NumKeys);
  assign raddr   = key_ext[AddrW-1:0];
  assign in_fire = in_i.valid && in_i.ready;

  // Stage 1 registers.
  logic                       s1_vld_q, s1_vld_d;
  logic [AddrW-1:0]           s1_addr_q;
  logic [kdlp_pkg::KeyW-1:0]  s1_key_q;
  logic                       s1_level_q;
  logic [kdlp_pkg::TimeW-1:0] s1_now_q;
  logic                       s1_ent_vld_q;

  logic [NumKeys-1:0]         ent_vld_q;
  logic                       byp_vld_q;
  logic [AddrW-1:0]           byp_addr_q;
  kdlp_pkg::entry_t           byp_data_q;

  logic [EntW-1:0]            rdata;
  kdlp_pkg::entry_t           cur;
  kdlp_pkg::entry_t           nxt;
  logic [kdlp_pkg::TimeW-1:0] elapsed;
  logic                       deb_met, lp_met;
  logic                       ev_vld;
  kdlp_pkg::event_e           ev;
  logic                       s1_adv;
  logic                       out_free;

  logic                       out_vld_q, out_vld_d;
  kdlp_pkg::event_e           out_ev_q;
  logic [kdlp_pkg::KeyW-1:0]  out_key_q;

  kdlp_ram #(
    .Width (EntW),
    .Depth (NumKeys)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (nxt),
    .re_i    (in_fire && key_ok),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // The newest write wins; an entry never written reads as its reset value.
  always_comb begin
    if (byp_vld_q && (byp_addr_q == s1_addr_q)) begin
      cur = byp_data_q;
    end else if (s1_ent_vld_q) begin
      cur = kdlp_pkg::entry_t'(rdata);
    end else begin
      cur = kdlp_pkg::EntryRst;
    end
  end

  assign elapsed = s1_now_q - cur.start;
  assign deb_met = elapsed >= deb_q;
  assign lp_met  = elapsed >= lp_q;

  always_comb begin
    nxt    = cur;
    ev_vld = 1'b0;
    ev     = kdlp_pkg::EV_PRESS;
    unique case (cur.phase)
      kdlp_pkg::PH_UP: begin
        if (!s1_level_q) begin
          nxt.start = s1_now_q;
          nxt.phase = kdlp_pkg::PH_DB_DOWN;
        end
      end
      kdlp_pkg::PH_DB_DOWN: begin
        if (s1_level_q) begin
          nxt.phase = kdlp_pkg::PH_UP;
        end else if (deb_met) begin
          nxt.phase = kdlp_pkg::PH_DOWN;
          ev_vld    = 1'b1;
          ev        = kdlp_pkg::EV_PRESS;
        end
      end
      kdlp_pkg::PH_DOWN: begin
        if (s1_level_q) begin
          nxt.start = s1_now_q;
          nxt.phase = kdlp_pkg::PH_DB_UP;
        end else if (lp_met) begin
          ev_vld = 1'b1;
          ev     = kdlp_pkg::EV_LONG;
        end
      end
      kdlp_pkg::PH_DB_UP: begin
        if (!s1_level_q) begin
          nxt.phase = kdlp_pkg::PH_DOWN;
        end else if (deb_met) begin
          nxt.phase = kdlp_pkg::PH_UP;
          ev_vld    = 1'b1;
          ev        = kdlp_pkg::EV_RELEASE;
        end
      end
      default: ;
    endcase
  end

  // A sample without an event never waits for the output register.
  assign out_free    = !out_vld_q || out_o.ready;
  assign s1_adv      = s1_vld_q && (!ev_vld || out_free);
  assign in_i.ready  = !s1_vld_q || s1_adv;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = key_ok;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_adv && ev_vld) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      byp_vld_q <= 1'b0;
      ent_vld_q <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (s1_adv) begin
        byp_vld_q            <= 1'b1;
        ent_vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q    <= raddr;
      s1_key_q     <= in_i.key_index;
      s1_level_q   <= in_i.level;
      s1_now_q     <= in_i.now;
      s1_ent_vld_q <= key_ok && ent_vld_q[raddr];
    end
    if (s1_adv) begin
      byp_addr_q <= s1_addr_q;
      byp_data_q <= nxt;
    end
    if (s1_adv && ev_vld) begin
      out_ev_q  <= ev;
      out_key_q <= s1_key_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.event_res = out_ev_q;
  assign out_o.event_key = out_key_q;

  // A transferred sample occupies stage 1 exactly when its key is in range.
  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (s1_vld_q == $past(key_ok)))
    else $error("stage 1 valid does not follow the transferred key range");

  // A write-back always marks its entry as holding real data.
  a_ent_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> ent_vld_q[$past(s1_addr_q)])
    else $error("written entry not marked valid");

  // A held stage 1 sample keeps its address so the bypass match stays correct.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_adv) |=> (s1_vld_q && $stable(s1_addr_q)))
    else $error("stalled stage 1 sample lost or changed");

  // An event is only produced when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && ev_vld) |-> out_free)
    else $error("event would overwrite an untaken result");

endmodule

`default_nettype wire

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumKeys       = kdlp_pkg::NumKeysDef;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxPrinted    = 40;

  typedef struct packed {
    logic [kdlp_pkg::KeyW-1:0]  key;
    logic                       level;
    logic [kdlp_pkg::TimeW-1:0] stamp;
  } scan_sample_t;

  typedef struct packed {
    kdlp_pkg::event_e          kind;
    logic [kdlp_pkg::KeyW-1:0] key;
  } key_event_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we;
  logic [kdlp_pkg::CfgIdxW-1:0]   cfg_index;
  logic [kdlp_pkg::TimeW-1:0]     cfg_wdata;

  kdlp_in_if  in_if();
  kdlp_out_if out_if();

  key_debounce_long_press #(.NumKeys(NumKeys)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Pending scan samples and the key events they are predicted to cause.
  scan_sample_t scan_q[$];
  key_event_t   expected_events[$];

  // Mirror of the per-key tracking state and the thresholds.
  logic [kdlp_pkg::TimeW-1:0] debounce_cfg = kdlp_pkg::DebounceRst;
  logic [kdlp_pkg::TimeW-1:0] long_press_cfg = kdlp_pkg::LongPressRst;
  kdlp_pkg::phase_e           key_phase_m[NumKeys];
  logic [kdlp_pkg::TimeW-1:0] key_start_m[NumKeys];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned n_pushed = 0;
  int unsigned n_samples = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_events[3] = '{0, 0, 0};

  logic [kdlp_pkg::TimeW-1:0] clock_now;
  bit   [NumKeys-1:0]         want_low;

  task automatic report_mismatch(input string msg);
    if (n_errors < MaxPrinted) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    n_errors++;
  endtask

  // Advances the mirrored key state by one sample and queues any event it causes.
  function automatic void track_key(input scan_sample_t s);
    logic [kdlp_pkg::TimeW-1:0] elapsed;
    int unsigned                k;
    k = 32'(s.key);
    if (k >= NumKeys) return;
    elapsed = s.stamp - key_start_m[k];
    case (key_phase_m[k])
      kdlp_pkg::PH_UP: begin
        if (!s.level) begin
          key_start_m[k] = s.stamp;
          key_phase_m[k] = kdlp_pkg::PH_DB_DOWN;
        end
      end
      kdlp_pkg::PH_DB_DOWN: begin
        if (s.level) begin
          key_phase_m[k] = kdlp_pkg::PH_UP;
        end else if (elapsed >= debounce_cfg) begin
          key_phase_m[k] = kdlp_pkg::PH_DOWN;
          expected_events.push_back('{kind: kdlp_pkg::EV_PRESS, key: s.key});
        end
      end
      kdlp_pkg::PH_DOWN: begin
        if (s.level) begin
          key_start_m[k] = s.stamp;
          key_phase_m[k] = kdlp_pkg::PH_DB_UP;
        end else if (elapsed >= long_press_cfg) begin
          expected_events.push_back('{kind: kdlp_pkg::EV_LONG, key: s.key});
        end
      end
      default: begin
        // A low sample while confirming release is a bounce; the start time stays.
        if (!s.level) begin
          key_phase_m[k] = kdlp_pkg::PH_DOWN;
        end else if (elapsed >= debounce_cfg) begin
          key_phase_m[k] = kdlp_pkg::PH_UP;
          expected_events.push_back('{kind: kdlp_pkg::EV_RELEASE, key: s.key});
        end
      end
    endcase
  endfunction

  // Driver: predicts on every transfer and keeps valid high until the sample is taken.
  always @(posedge clk_i) begin
    logic         take;
    scan_sample_t s;
    take = in_if.valid && in_if.ready;
    if (take) begin
      track_key('{key: in_if.key_index, level: in_if.level, stamp: in_if.now});
      n_samples++;
    end
    if (rst_ni && (!in_if.valid || take)) begin
      if (scan_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s = scan_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.key_index <= s.key;
        in_if.level     <= s.level;
        in_if.now       <= s.stamp;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Monitor: every event transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    key_event_t e;
    if (out_if.valid && out_if.ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d for key %0d",
                                  out_if.event_res, out_if.event_key));
      end else begin
        e = expected_events.pop_front();
        if (out_if.event_res !== e.kind) begin
          report_mismatch($sformatf("event kind %0d, expected %s (key %0d)",
                                    out_if.event_res, e.kind.name(), e.key));
        end
        if (out_if.event_key !== e.key) begin
          report_mismatch($sformatf("event key %0d, expected %0d (%s)",
                                    out_if.event_key, e.key, e.kind.name()));
        end
        n_events[int'(e.kind)]++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [kdlp_pkg::KeyW-1:0] key, input logic level,
                             input logic [kdlp_pkg::TimeW-1:0] stamp);
    scan_q.push_back('{key: key, level: level, stamp: stamp});
    n_pushed++;
  endtask

  // Returns on a falling edge once every sample has transferred and every event arrived.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (n_pushed != n_samples || expected_events.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input kdlp_pkg::cfg_idx_e idx,
                           input logic [kdlp_pkg::TimeW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == kdlp_pkg::CFG_DEBOUNCE) begin
      debounce_cfg = val;
    end else begin
      long_press_cfg = val;
    end
  endtask

  task automatic set_thresholds(input logic [kdlp_pkg::TimeW-1:0] db,
                                input logic [kdlp_pkg::TimeW-1:0] lp);
    write_reg(kdlp_pkg::CFG_DEBOUNCE, db);
    write_reg(kdlp_pkg::CFG_LONG_PRESS, lp);
    n_settings++;
    @(negedge clk_i);
  endtask

  // Mostly coherent press and release sequences with bounces; some samples are pure noise.
  task automatic random_samples(input int unsigned n, input int unsigned step_max,
                                input int unsigned noise_pct);
    int unsigned k;
    logic        lvl;
    for (int i = 0; i < n; i++) begin
      clock_now += $urandom_range(step_max, 0);
      if ($urandom_range(99) < noise_pct) begin
        push_sample(kdlp_pkg::KeyW'($urandom_range(NumKeys - 1)),
                    1'($urandom_range(1)), $urandom());
      end else begin
        k = $urandom_range(NumKeys - 1);
        if ($urandom_range(99) < 12) want_low[k] = !want_low[k];
        lvl = !want_low[k];
        if ($urandom_range(99) < 8) lvl = !lvl;
        push_sample(kdlp_pkg::KeyW'(k), lvl, clock_now);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NumKeys; i++) begin
      key_phase_m[i] = kdlp_pkg::PH_UP;
      key_start_m[i] = '0;
    end
    want_low        = '0;
    cfg_we          = 1'b0;
    cfg_index       = kdlp_pkg::CFG_DEBOUNCE;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.key_index = '0;
    in_if.level     = 1'b1;
    in_if.now       = '0;
    out_if.ready    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset thresholds: press, repeated long press, a bounce during release that
    // keeps the release start time, then a clean release.
    n_settings++;
    push_sample(3'd0, 1'b0, 32'd100);
    push_sample(3'd0, 1'b0, 32'd149);
    push_sample(3'd0, 1'b0, 32'd150);
    push_sample(3'd0, 1'b0, 32'd600);
    push_sample(3'd0, 1'b0, 32'd601);
    push_sample(3'd0, 1'b1, 32'd700);
    push_sample(3'd0, 1'b0, 32'd710);
    push_sample(3'd0, 1'b0, 32'd1199);
    push_sample(3'd0, 1'b0, 32'd1200);
    push_sample(3'd0, 1'b1, 32'd1300);
    push_sample(3'd0, 1'b1, 32'd1349);
    push_sample(3'd0, 1'b1, 32'd1350);
    // A bounce while confirming a press drops the key back to up.
    push_sample(3'd7, 1'b0, 32'd2000);
    push_sample(3'd7, 1'b1, 32'd2010);
    push_sample(3'd7, 1'b1, 32'd2020);
    wait_idle();

    // Zero thresholds are met on the very next sample.
    set_thresholds('0, '0);
    push_sample(3'd3, 1'b0, 32'd5);
    push_sample(3'd3, 1'b0, 32'd5);
    push_sample(3'd3, 1'b0, 32'd5);
    push_sample(3'd3, 1'b1, 32'd6);
    push_sample(3'd3, 1'b1, 32'd6);
    wait_idle();

    // Largest thresholds: only a wrapped difference of all ones reaches them.
    set_thresholds('1, '1);
    push_sample(3'd5, 1'b0, 32'd1000);
    push_sample(3'd5, 1'b0, 32'd999);
    push_sample(3'd5, 1'b0, 32'd998);
    push_sample(3'd5, 1'b0, 32'd999);
    wait_idle();

    clock_now = 32'd5000;
    set_thresholds(32'd20, 32'd150);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    random_samples(80, 10, 5);
    wait_idle();

    // Time stamps wrap through zero in this phase.
    clock_now = 32'hFFFF_FFC0;
    set_thresholds(32'd5, 32'd40);
    src_idle_pct  = 65;
    snk_stall_pct = 0;
    random_samples(80, 3, 5);
    wait_idle();

    set_thresholds(kdlp_pkg::DebounceRst, kdlp_pkg::LongPressRst);
    src_idle_pct  = 0;
    snk_stall_pct = 65;
    random_samples(80, 30, 5);
    wait_idle();

    set_thresholds(32'd0, 32'd0);
    src_idle_pct  = 19;
    snk_stall_pct = 19;
    random_samples(80, 2, 5);
    wait_idle();

    // The receiver holds off while samples keep coming, so the block backs up.
    set_thresholds(32'd1, 32'd3);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_seq++;
    random_samples(80, 1, 5);
    wait_idle();

    $display("Ran %0d scan samples under %0d threshold settings.", n_samples, n_settings);
    $display("Checked %0d press, %0d release and %0d long-press events.",
             n_events[0], n_events[1], n_events[2]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
src/kdlp_pkg.sv
src/kdlp_in_if.sv
src/kdlp_out_if.sv
src/kdlp_ram.sv
src/key_debounce_long_press.sv
dv/tb_top.sv
